// ===== rtl/login_heartbeat_keepalive_fsm_defines.svh =====
// Assertion macros for the login, heartbeat and keepalive controller.
`ifndef LOGIN_HEARTBEAT_KEEPALIVE_FSM_DEFINES_SVH
`define LOGIN_HEARTBEAT_KEEPALIVE_FSM_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define LHK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define LHK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lhk_pkg.sv =====
// Types and codes shared by the login, heartbeat and keepalive controller.
package lhk_pkg;

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_AUTH_SEND  = 8'b0000_0010,
        ST_AUTH_WAIT  = 8'b0000_0100,
        ST_HB_SEND    = 8'b0000_1000,
        ST_HB_WAIT    = 8'b0001_0000,
        ST_READY_SEND = 8'b0010_0000,
        ST_READY_WAIT = 8'b0100_0000,
        ST_CONFIRM    = 8'b1000_0000
    } t_state;

    // External state codes
    localparam logic [2:0] CODE_IDLE       = 3'd0;
    localparam logic [2:0] CODE_AUTH_SEND  = 3'd1;
    localparam logic [2:0] CODE_AUTH_WAIT  = 3'd2;
    localparam logic [2:0] CODE_HB_SEND    = 3'd3;
    localparam logic [2:0] CODE_HB_WAIT    = 3'd4;
    localparam logic [2:0] CODE_READY_SEND = 3'd5;
    localparam logic [2:0] CODE_READY_WAIT = 3'd6;
    localparam logic [2:0] CODE_CONFIRM    = 3'd7;

    // Item kinds
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_AUTH_ACK  = 3'd1;
    localparam logic [2:0] KIND_HB_ACK    = 3'd2;
    localparam logic [2:0] KIND_READY_ACK = 3'd3;
    localparam logic [2:0] KIND_TRAVERSAL = 3'd4;
    localparam logic [2:0] KIND_READY_REQ = 3'd5;

    // Request codes
    localparam logic [2:0] MSG_NONE    = 3'd0;
    localparam logic [2:0] MSG_LOGIN   = 3'd1;
    localparam logic [2:0] MSG_HB      = 3'd2;
    localparam logic [2:0] MSG_READY   = 3'd3;
    localparam logic [2:0] MSG_CONFIRM = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_AUTH_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_AUTH_RETRY    = 3'd1;
    localparam logic [2:0] REG_HB_TIMEOUT    = 3'd2;
    localparam logic [2:0] REG_HB_RETRY      = 3'd3;
    localparam logic [2:0] REG_READY_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_READY_RETRY   = 3'd5;
    localparam logic [2:0] REG_RELOGIN       = 3'd6;
    localparam logic [2:0] REG_TRAVERSAL     = 3'd7;

    localparam int CFG_W = 24;

    function automatic logic [2:0] state_code(input t_state st);
        logic [2:0] code;
        case (st)
            ST_IDLE:       code = CODE_IDLE;
            ST_AUTH_SEND:  code = CODE_AUTH_SEND;
            ST_AUTH_WAIT:  code = CODE_AUTH_WAIT;
            ST_HB_SEND:    code = CODE_HB_SEND;
            ST_HB_WAIT:    code = CODE_HB_WAIT;
            ST_READY_SEND: code = CODE_READY_SEND;
            ST_READY_WAIT: code = CODE_READY_WAIT;
            ST_CONFIRM:    code = CODE_CONFIRM;
            default:       code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/login_heartbeat_keepalive_fsm.sv =====
// Top level of the login, heartbeat and relay-ready client controller.
//
// Takes one beat per cycle unless o_in_stall is high: ticks and parsed server responses
// enter an input register, the protocol state, timers and retry counters are updated in
// one pass, and the request code, new state and failure/address flags land in the result
// register on the next edge. Throughput is one item per cycle when the output does not
// stall, set by the single state update pass. While a result is held by o_out_valid
// and i_out_stall, the input register still takes one more beat before o_in_stall rises.
// Configuration writes go through i_cfg_we/i_cfg_idx/i_cfg_data and take effect at once.
`include "login_heartbeat_keepalive_fsm_defines.svh"

module login_heartbeat_keepalive_fsm
    import lhk_pkg::*;
#(
    parameter int AGE_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [2:0]       i_kind,
    input  logic             i_plat_valid,
    input  logic [31:0]      i_ext_ip,
    input  logic [15:0]      i_ext_port,
    input  logic             i_online,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_send_msg,
    output logic [2:0]       o_fsm_state,
    output logic             o_login_failed,
    output logic             o_addr_changed
);

    localparam int CMP_W = (AGE_BITS > CFG_W) ? AGE_BITS : CFG_W;

    // configuration
    logic [15:0] r_auth_timeout, r_hb_timeout, r_ready_timeout;
    logic [7:0]  r_auth_limit, r_hb_limit, r_ready_limit;
    logic [23:0] r_relogin_period;
    logic        r_traversal_en;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_kind;
    logic        r_plat;
    logic [31:0] r_ip;
    logic [15:0] r_port;
    logic        r_online;

    // protocol state
    t_state      r_state, n_state;
    logic        r_auth_ack, n_auth_ack, r_hb_ack, n_hb_ack, r_ready_ack, n_ready_ack;
    logic [15:0] r_wait, n_wait;
    logic [AGE_BITS-1:0] r_age, n_age;
    logic [7:0]  r_auth_retries, n_auth_retries;
    logic [7:0]  r_hb_retries, n_hb_retries;
    logic [7:0]  r_ready_retries, n_ready_retries;
    logic [31:0] r_known_ip, n_known_ip;
    logic [15:0] r_known_port, n_known_port;
    logic        r_addr_known, n_addr_known;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_send_msg, n_send_msg;
    logic [2:0]  r_fsm_state;
    logic        r_failed, n_failed;
    logic        r_changed, n_changed;

    logic        advance;
    logic        in_wait;
    logic [15:0] wait_inc;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    // hold off the sender while in reset
    assign o_in_stall = !i_rst_n || (r_in_valid && r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auth_timeout   <= 16'd5;
            r_auth_limit     <= 8'd3;
            r_hb_timeout     <= 16'd10;
            r_hb_limit       <= 8'd3;
            r_ready_timeout  <= 16'd5;
            r_ready_limit    <= 8'd3;
            r_relogin_period <= 24'd3600;
            r_traversal_en   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_AUTH_TIMEOUT:  r_auth_timeout   <= i_cfg_data[15:0];
                REG_AUTH_RETRY:    r_auth_limit     <= i_cfg_data[7:0];
                REG_HB_TIMEOUT:    r_hb_timeout     <= i_cfg_data[15:0];
                REG_HB_RETRY:      r_hb_limit       <= i_cfg_data[7:0];
                REG_READY_TIMEOUT: r_ready_timeout  <= i_cfg_data[15:0];
                REG_READY_RETRY:   r_ready_limit    <= i_cfg_data[7:0];
                REG_RELOGIN:       r_relogin_period <= i_cfg_data[23:0];
                REG_TRAVERSAL:     r_traversal_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_kind   <= i_kind;
            r_plat   <= i_plat_valid;
            r_ip     <= i_ext_ip;
            r_port   <= i_ext_port;
            r_online <= i_online;
        end
    end

    assign in_wait  = (r_state == ST_AUTH_WAIT) || (r_state == ST_HB_WAIT) ||
                      (r_state == ST_READY_WAIT);
    assign wait_inc = (in_wait && r_wait != 16'hFFFF) ? r_wait + 16'd1 : r_wait;

    always_comb begin
        n_state         = r_state;
        n_auth_ack      = r_auth_ack;
        n_hb_ack        = r_hb_ack;
        n_ready_ack     = r_ready_ack;
        n_wait          = r_wait;
        n_age           = r_age;
        n_auth_retries  = r_auth_retries;
        n_hb_retries    = r_hb_retries;
        n_ready_retries = r_ready_retries;
        n_known_ip      = r_known_ip;
        n_known_port    = r_known_port;
        n_addr_known    = r_addr_known;
        n_send_msg      = MSG_NONE;
        n_failed        = 1'b0;
        n_changed       = 1'b0;

        case (r_kind)
            KIND_TICK: begin
                if (r_plat) begin
                    n_age  = (r_age != {AGE_BITS{1'b1}}) ? r_age + 1'b1 : r_age;
                    n_wait = wait_inc;
                    case (r_state)
                        ST_IDLE: begin
                            n_state        = ST_AUTH_SEND;
                            n_auth_retries = '0;
                        end
                        ST_AUTH_SEND: begin
                            n_auth_ack = 1'b0;
                            n_send_msg = MSG_LOGIN;
                            n_wait     = '0;
                            n_state    = ST_AUTH_WAIT;
                        end
                        ST_AUTH_WAIT: begin
                            if (r_auth_ack || wait_inc >= r_auth_timeout) begin
                                if (r_auth_ack) begin
                                    n_age        = '0;
                                    n_hb_retries = '0;
                                    n_state      = ST_HB_SEND;
                                end else begin
                                    n_auth_retries = r_auth_retries + 8'd1;
                                    n_state        = ST_AUTH_SEND;
                                end
                                if (n_auth_retries >= r_auth_limit) begin
                                    n_auth_retries = '0;
                                    n_state        = ST_IDLE;
                                    n_failed       = 1'b1;
                                end
                            end
                        end
                        ST_HB_SEND: begin
                            n_hb_ack   = 1'b0;
                            n_send_msg = MSG_HB;
                            n_wait     = '0;
                            n_state    = ST_HB_WAIT;
                        end
                        ST_HB_WAIT: begin
                            if (r_hb_ack || wait_inc >= r_hb_timeout) begin
                                if (!r_hb_ack) begin
                                    n_hb_retries = r_hb_retries + 8'd1;
                                    n_state      = ST_HB_SEND;
                                end else if (wait_inc >= r_hb_timeout) begin
                                    n_state = ST_HB_SEND;
                                end
                                if (n_hb_retries >= r_hb_limit) begin
                                    n_hb_retries = '0;
                                    n_state      = ST_IDLE;
                                end
                            end
                            // force a fresh login once the login is too old
                            if (CMP_W'(n_age) > CMP_W'(r_relogin_period)) begin
                                n_state = ST_IDLE;
                            end
                        end
                        ST_READY_SEND: begin
                            n_ready_ack = 1'b0;
                            n_send_msg  = MSG_READY;
                            n_wait      = '0;
                            n_state     = ST_READY_WAIT;
                        end
                        ST_READY_WAIT: begin
                            if (r_ready_ack || wait_inc >= r_ready_timeout) begin
                                if (r_ready_ack) begin
                                    n_state = ST_HB_SEND;
                                end else begin
                                    n_ready_retries = r_ready_retries + 8'd1;
                                    n_state         = ST_READY_SEND;
                                end
                                if (n_ready_retries >= r_ready_limit) begin
                                    n_ready_retries = '0;
                                    n_state         = ST_HB_SEND;
                                end
                            end
                        end
                        ST_CONFIRM: begin
                            n_send_msg = MSG_CONFIRM;
                            n_state    = ST_HB_SEND;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            KIND_AUTH_ACK: begin
                n_auth_ack = 1'b1;
            end
            KIND_HB_ACK: begin
                n_hb_ack = 1'b1;
                if (r_state == ST_HB_WAIT) begin
                    if (!r_addr_known) begin
                        n_known_ip   = r_ip;
                        n_known_port = r_port;
                        n_addr_known = 1'b1;
                        if (!r_online) begin
                            n_state = ST_IDLE;
                        end
                    end else if (r_known_ip != r_ip || r_known_port != r_port) begin
                        // address moved: relogin regardless of online status
                        n_known_ip   = r_ip;
                        n_known_port = r_port;
                        n_state      = ST_AUTH_SEND;
                        n_changed    = 1'b1;
                    end else if (!r_online) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            KIND_READY_ACK: begin
                n_ready_ack = 1'b1;
            end
            KIND_TRAVERSAL: begin
                if (r_traversal_en) begin
                    n_state = ST_CONFIRM;
                end
            end
            KIND_READY_REQ: begin
                n_state = ST_READY_SEND;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_AUTH_SEND;
            r_auth_ack      <= 1'b0;
            r_hb_ack        <= 1'b0;
            r_ready_ack     <= 1'b0;
            r_wait          <= '0;
            r_age           <= '0;
            r_auth_retries  <= '0;
            r_hb_retries    <= '0;
            r_ready_retries <= '0;
            r_known_ip      <= '0;
            r_known_port    <= '0;
            r_addr_known    <= 1'b0;
        end else if (advance) begin
            r_state         <= n_state;
            r_auth_ack      <= n_auth_ack;
            r_hb_ack        <= n_hb_ack;
            r_ready_ack     <= n_ready_ack;
            r_wait          <= n_wait;
            r_age           <= n_age;
            r_auth_retries  <= n_auth_retries;
            r_hb_retries    <= n_hb_retries;
            r_ready_retries <= n_ready_retries;
            r_known_ip      <= n_known_ip;
            r_known_port    <= n_known_port;
            r_addr_known    <= n_addr_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_send_msg  <= n_send_msg;
            r_fsm_state <= state_code(n_state);
            r_failed    <= n_failed;
            r_changed   <= n_changed;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_send_msg     = r_send_msg;
    assign o_fsm_state    = r_fsm_state;
    assign o_login_failed = r_failed;
    assign o_addr_changed = r_changed;

    `LHK_ASSERT_NOW(a_fail_goes_idle, r_out_valid && r_failed, r_fsm_state == CODE_IDLE, "login failure without idle state")
    `LHK_ASSERT_NOW(a_login_to_wait, r_out_valid && r_send_msg == MSG_LOGIN, r_fsm_state == CODE_AUTH_WAIT, "login sent but not waiting for ack")
    `LHK_ASSERT_NOW(a_change_relogin, r_out_valid && r_changed, r_fsm_state == CODE_AUTH_SEND && r_send_msg == MSG_NONE, "address change without relogin")
    `LHK_ASSERT_NEXT(a_advance_result, advance, r_out_valid, "processed beat produced no result")

endmodule

// ===== verif/lhk_reply_checker.sv =====
// Reply predictor and checker for the login, heartbeat and keepalive controller.
module lhk_reply_checker
    import lhk_pkg::*;
#(
    parameter int AGE_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [2:0]       i_kind,
    input  logic             i_plat_valid,
    input  logic [31:0]      i_ext_ip,
    input  logic [15:0]      i_ext_port,
    input  logic             i_online,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [2:0]       i_send_msg,
    input  logic [2:0]       i_fsm_state,
    input  logic             i_login_failed,
    input  logic             i_addr_changed,
    output int               o_fail_count,
    output int               o_backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0] send_msg;
        logic [2:0] fsm_state;
        logic       login_failed;
        logic       addr_changed;
    } t_reply;

    t_reply pending_replies[$];
    int     mismatches = 0;

    // Register copies
    logic [15:0] cfg_auth_timeout;
    logic [7:0]  cfg_auth_retry;
    logic [15:0] cfg_hb_timeout;
    logic [7:0]  cfg_hb_retry;
    logic [15:0] cfg_ready_timeout;
    logic [7:0]  cfg_ready_retry;
    logic [23:0] cfg_relogin;
    logic        cfg_traversal;

    // Session state
    logic [2:0]          sess_state;
    logic                auth_acked, hb_acked, ready_acked, addr_valid;
    logic [15:0]         wait_count;
    logic [AGE_BITS-1:0] age;
    logic [7:0]          auth_tries, hb_tries, ready_tries;
    logic [31:0]         peer_ip;
    logic [15:0]         peer_port;

    task automatic reset_session();
        cfg_auth_timeout  = 16'd5;
        cfg_auth_retry    = 8'd3;
        cfg_hb_timeout    = 16'd10;
        cfg_hb_retry      = 8'd3;
        cfg_ready_timeout = 16'd5;
        cfg_ready_retry   = 8'd3;
        cfg_relogin       = 24'd3600;
        cfg_traversal     = 1'b1;
        sess_state  = CODE_AUTH_SEND;
        auth_acked  = 1'b0;
        hb_acked    = 1'b0;
        ready_acked = 1'b0;
        addr_valid  = 1'b0;
        wait_count  = '0;
        age         = '0;
        auth_tries  = '0;
        hb_tries    = '0;
        ready_tries = '0;
        peer_ip     = '0;
        peer_port   = '0;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        case (idx)
            REG_AUTH_TIMEOUT:  cfg_auth_timeout  = val[15:0];
            REG_AUTH_RETRY:    cfg_auth_retry    = val[7:0];
            REG_HB_TIMEOUT:    cfg_hb_timeout    = val[15:0];
            REG_HB_RETRY:      cfg_hb_retry      = val[7:0];
            REG_READY_TIMEOUT: cfg_ready_timeout = val[15:0];
            REG_READY_RETRY:   cfg_ready_retry   = val[7:0];
            REG_RELOGIN:       cfg_relogin       = val[23:0];
            REG_TRAVERSAL:     cfg_traversal     = val[0];
            default: ;
        endcase
    endtask

    task automatic advance_on_tick(output logic [2:0] msg, output logic failed);
        msg    = MSG_NONE;
        failed = 1'b0;
        if (age != {AGE_BITS{1'b1}}) age = age + 1'b1;
        if ((sess_state == CODE_AUTH_WAIT || sess_state == CODE_HB_WAIT ||
             sess_state == CODE_READY_WAIT) && wait_count != 16'hFFFF)
            wait_count = wait_count + 1'b1;

        case (sess_state)
            CODE_IDLE: begin
                sess_state = CODE_AUTH_SEND;
                auth_tries = '0;
            end
            CODE_AUTH_SEND: begin
                auth_acked = 1'b0;
                msg        = MSG_LOGIN;
                wait_count = '0;
                sess_state = CODE_AUTH_WAIT;
            end
            CODE_AUTH_WAIT: begin
                if (auth_acked || wait_count >= cfg_auth_timeout) begin
                    if (auth_acked) begin
                        age        = '0;
                        hb_tries   = '0;
                        sess_state = CODE_HB_SEND;
                    end else begin
                        auth_tries = auth_tries + 1'b1;
                        sess_state = CODE_AUTH_SEND;
                    end
                    if (auth_tries >= cfg_auth_retry) begin
                        auth_tries = '0;
                        sess_state = CODE_IDLE;
                        failed     = 1'b1;
                    end
                end
            end
            CODE_HB_SEND: begin
                hb_acked   = 1'b0;
                msg        = MSG_HB;
                wait_count = '0;
                sess_state = CODE_HB_WAIT;
            end
            CODE_HB_WAIT: begin
                if (hb_acked || wait_count >= cfg_hb_timeout) begin
                    // an acked heartbeat still waits out the period
                    if (hb_acked) begin
                        if (wait_count >= cfg_hb_timeout) sess_state = CODE_HB_SEND;
                    end else begin
                        hb_tries   = hb_tries + 1'b1;
                        sess_state = CODE_HB_SEND;
                    end
                    if (hb_tries >= cfg_hb_retry) begin
                        hb_tries   = '0;
                        sess_state = CODE_IDLE;
                    end
                end
                if (age > cfg_relogin) sess_state = CODE_IDLE;
            end
            CODE_READY_SEND: begin
                ready_acked = 1'b0;
                msg         = MSG_READY;
                wait_count  = '0;
                sess_state  = CODE_READY_WAIT;
            end
            CODE_READY_WAIT: begin
                if (ready_acked || wait_count >= cfg_ready_timeout) begin
                    if (ready_acked) begin
                        sess_state = CODE_HB_SEND;
                    end else begin
                        ready_tries = ready_tries + 1'b1;
                        sess_state  = CODE_READY_SEND;
                    end
                    if (ready_tries >= cfg_ready_retry) begin
                        ready_tries = '0;
                        sess_state  = CODE_HB_SEND;
                    end
                end
            end
            default: begin
                msg        = MSG_CONFIRM;
                sess_state = CODE_HB_SEND;
            end
        endcase
    endtask

    task automatic predict_reply(
        input  logic [2:0]  kind,
        input  logic        plat,
        input  logic [31:0] ip,
        input  logic [15:0] port,
        input  logic        online,
        output t_reply      r
    );
        logic [2:0] msg;
        logic       failed;
        logic       changed;
        msg     = MSG_NONE;
        failed  = 1'b0;
        changed = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (plat) advance_on_tick(msg, failed);
            end
            KIND_AUTH_ACK: auth_acked = 1'b1;
            KIND_HB_ACK: begin
                hb_acked = 1'b1;
                if (sess_state == CODE_HB_WAIT) begin
                    if (!addr_valid) begin
                        peer_ip    = ip;
                        peer_port  = port;
                        addr_valid = 1'b1;
                        if (!online) sess_state = CODE_IDLE;
                    end else if (peer_ip != ip || peer_port != port) begin
                        // new address: relogin, online flag not looked at
                        peer_ip    = ip;
                        peer_port  = port;
                        sess_state = CODE_AUTH_SEND;
                        changed    = 1'b1;
                    end else if (!online) begin
                        sess_state = CODE_IDLE;
                    end
                end
            end
            KIND_READY_ACK: ready_acked = 1'b1;
            KIND_TRAVERSAL: begin
                if (cfg_traversal) sess_state = CODE_CONFIRM;
            end
            KIND_READY_REQ: sess_state = CODE_READY_SEND;
            default: ;
        endcase
        r.send_msg     = msg;
        r.fsm_state    = sess_state;
        r.login_failed = failed;
        r.addr_changed = changed;
    endtask

    task automatic check_field(input string field, input logic [2:0] want, input logic [2:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            reset_session();
            pending_replies.delete();
        end else begin
            if (i_cfg_we) write_register(i_cfg_idx, i_cfg_data);
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    $error("reply beat with nothing pending: msg %0d state %0d",
                           i_send_msg, i_fsm_state);
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("send_msg", want.send_msg, i_send_msg);
                    check_field("fsm_state", want.fsm_state, i_fsm_state);
                    check_field("login_failed", {2'b00, want.login_failed},
                                {2'b00, i_login_failed});
                    check_field("addr_changed", {2'b00, want.addr_changed},
                                {2'b00, i_addr_changed});
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_reply(i_kind, i_plat_valid, i_ext_ip, i_ext_port, i_online, want);
                pending_replies.push_back(want);
            end
        end
        o_backlog    <= pending_replies.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== verif/tb_top.sv =====
// Stimulus and verdict for the login, heartbeat and keepalive controller.
module tb_top
    import lhk_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [2:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [2:0]       i_kind = '0;
    logic             i_plat_valid = 1'b0;
    logic [31:0]      i_ext_ip = '0;
    logic [15:0]      i_ext_port = '0;
    logic             i_online = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [2:0]       o_send_msg;
    logic [2:0]       o_fsm_state;
    logic             o_login_failed;
    logic             o_addr_changed;

    int          fail_count;
    int          backlog;
    int          items_sent = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    bit          squeeze_req = 1'b0;
    logic [31:0] cur_ip = '0;
    logic [15:0] cur_port = '0;

    always #6 i_clk = ~i_clk;

    login_heartbeat_keepalive_fsm dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_plat_valid   (i_plat_valid),
        .i_ext_ip       (i_ext_ip),
        .i_ext_port     (i_ext_port),
        .i_online       (i_online),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_send_msg     (o_send_msg),
        .o_fsm_state    (o_fsm_state),
        .o_login_failed (o_login_failed),
        .o_addr_changed (o_addr_changed)
    );

    lhk_reply_checker u_reply_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_plat_valid   (i_plat_valid),
        .i_ext_ip       (i_ext_ip),
        .i_ext_port     (i_ext_port),
        .i_online       (i_online),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_send_msg     (o_send_msg),
        .i_fsm_state    (o_fsm_state),
        .i_login_failed (o_login_failed),
        .i_addr_changed (o_addr_changed),
        .o_fail_count   (fail_count),
        .o_backlog      (backlog)
    );

    // Offer one beat, optionally after a gap, and hold it until taken.
    task automatic send_item(
        input logic [2:0]  kind,
        input logic        plat,
        input logic [31:0] ip,
        input logic [15:0] port,
        input logic        online
    );
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_plat_valid <= plat;
        i_ext_ip     <= ip;
        i_ext_port   <= port;
        i_online     <= online;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Kind with random filler in the fields it does not use.
    task automatic send_kind(input logic [2:0] kind);
        send_item(kind, $urandom_range(0, 9) != 0, $urandom, 16'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_hb_ack(input logic online);
        send_item(KIND_HB_ACK, 1'($urandom_range(0, 1)), cur_ip, cur_port, online);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_regs(
        input logic [15:0] auth_to, input logic [7:0] auth_retry,
        input logic [15:0] hb_to,   input logic [7:0] hb_retry,
        input logic [15:0] rdy_to,  input logic [7:0] rdy_retry,
        input logic [23:0] relogin, input logic       traversal
    );
        write_reg(REG_AUTH_TIMEOUT, CFG_W'(auth_to));
        write_reg(REG_AUTH_RETRY, CFG_W'(auth_retry));
        write_reg(REG_HB_TIMEOUT, CFG_W'(hb_to));
        write_reg(REG_HB_RETRY, CFG_W'(hb_retry));
        write_reg(REG_READY_TIMEOUT, CFG_W'(rdy_to));
        write_reg(REG_READY_RETRY, CFG_W'(rdy_retry));
        write_reg(REG_RELOGIN, CFG_W'(relogin));
        write_reg(REG_TRAVERSAL, CFG_W'(traversal));
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every reply, then let the pipeline empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (backlog != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Login, then a run of heartbeat acks with the odd detour.
    task automatic run_session();
        int rounds;
        int pick;
        send_kind(KIND_TICK);
        send_kind(KIND_TICK);
        repeat ($urandom_range(0, 2)) send_kind(KIND_TICK);
        if ($urandom_range(0, 9) != 0) send_kind(KIND_AUTH_ACK);
        send_kind(KIND_TICK);
        send_kind(KIND_TICK);
        rounds = $urandom_range(2, 8);
        repeat (rounds) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                send_hb_ack(1'b1);
            end else if (pick < 84) begin
                cur_ip   = $urandom;
                cur_port = 16'($urandom_range(0, 65535));
                send_hb_ack(1'($urandom_range(0, 1)));
            end else if (pick < 88) begin
                send_hb_ack(1'b0);
            end else if (pick < 92) begin
                send_kind(KIND_TRAVERSAL);
            end else if (pick < 96) begin
                send_kind(KIND_READY_REQ);
                send_kind(KIND_TICK);
                send_kind(KIND_TICK);
                if ($urandom_range(0, 9) < 7) send_kind(KIND_READY_ACK);
            end else begin
                send_kind(KIND_READY_ACK);
            end
            repeat ($urandom_range(0, 4)) send_kind(KIND_TICK);
        end
    endtask

    task automatic fill_random(input int target);
        while (items_sent < target) begin
            if ($urandom_range(0, 9) < 6) begin
                run_session();
            end else begin
                send_item(3'($urandom_range(0, 5)), 1'($urandom_range(0, 1)), $urandom,
                          16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Reply side: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        #4_000_000;
        $display("[login_heartbeat_keepalive_fsm] ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through login, heartbeat, relogin, confirm and ready.
        send_item(KIND_TICK, 1'b0, 32'h0, 16'h0, 1'b0);
        send_item(KIND_TICK, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(KIND_AUTH_ACK, 1'b0, 32'h0, 16'h0, 1'b0);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_HB_ACK, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_HB_ACK, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(KIND_HB_ACK, 1'b1, 32'h0, 16'h0, 1'b1);
        send_item(KIND_TICK, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(KIND_AUTH_ACK, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_HB_ACK, 1'b0, 32'h0, 16'h0, 1'b0);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_TRAVERSAL, 1'b0, 32'h0, 16'h0, 1'b0);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_READY_REQ, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_READY_ACK, 1'b0, 32'h0, 16'h0, 1'b0);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_READY_ACK, 1'b1, 32'hAAAA_AAAA, 16'hAAAA, 1'b1);
        send_item(KIND_TICK, 1'b1, 32'h0, 16'h0, 1'b0);
        send_item(KIND_HB_ACK, 1'b1, 32'h5555_5555, 16'h5555, 1'b0);
        cur_ip   = 32'h5555_5555;
        cur_port = 16'h5555;
        settle();

        // Short timeouts and a relogin period that expires mid-session.
        program_regs(16'd3, 8'd2, 16'd4, 8'd2, 16'd2, 8'd2, 24'd40, 1'b1);
        gap_pct     = 10;
        stall_pct   = 10;
        squeeze_req = 1'b1;
        fill_random(items_sent + 320);
        settle();

        // Low extremes, traversal off.
        program_regs(16'd1, 8'd1, 16'd1, 8'd1, 16'd1, 8'd1, 24'd1, 1'b0);
        gap_pct   = 25;
        stall_pct = 5;
        fill_random(items_sent + 320);
        settle();

        // High extremes: waits only end on an ack.
        program_regs(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 24'hFF_FFFF, 1'b1);
        gap_pct   = 15;
        stall_pct = 15;
        fill_random(items_sent + 320);
        settle();

        // Random small setting, run back to back.
        program_regs(16'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
                     16'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
                     16'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
                     24'($urandom_range(5, 200)), 1'($urandom_range(0, 1)));
        gap_pct   = 0;
        stall_pct = 0;
        fill_random(items_sent + 320);
        settle();

        if (fail_count == 0) begin
            $display("[login_heartbeat_keepalive_fsm] OK");
        end else begin
            $display("[login_heartbeat_keepalive_fsm] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lhk_pkg.sv
rtl/login_heartbeat_keepalive_fsm.sv
verif/lhk_reply_checker.sv
verif/tb_top.sv
